[design/positional_deque_list_top_assert.svh]
// Assertion macros shared by the list controller.
`ifndef POSITIONAL_DEQUE_LIST_TOP_ASSERT_SVH
`define POSITIONAL_DEQUE_LIST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PDL_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PDL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pdl_pkg.sv]
package pdl_pkg;

    // List geometry
    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // Transaction field widths
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;

    // Width for comparing a requested position against the count
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_POS   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DUMP      = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SHIFT_DRAIN,
        S_FINISH,
        S_DUMP,
        S_DUMP_DRAIN
    } state_t;

    // Entry memory request: one write port, one read port
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

endpackage

[design/pdl_ram.sv]
module pdl_ram
    import pdl_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [LIST_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

[design/pdl_ctrl.sv]
module pdl_ctrl
    import pdl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [POS_W-1:0]         position,
    output logic                     busy,
    output ram_req_t                 ram_req,
    input  logic [DATA_W-1:0]        ram_rdata,
    output logic                     result_strobe,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] entry_value,
    output logic [CNT_W-1:0]         list_length,
    output logic                     last_result
);

    `include "positional_deque_list_top_assert.svh"

    localparam int SUM_W = CNT_W + 1;

    // Ring slot of a list offset: front plus offset, wrapped once
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] front,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(LIST_DEPTH))
        begin
            sum = sum - SUM_W'(LIST_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]      stop_reg, stop_next;
    logic                  ins_reg, ins_next;
    logic [DATA_W-1:0]     val_reg, val_next;
    logic [IDX_W-1:0]      ins_slot_reg, ins_slot_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]      dst_reg, dst_next;
    logic                  dump_pend_reg, dump_pend_next;
    logic                  dump_last_reg, dump_last_next;
    logic                  strobe_reg, strobe_next;
    logic [STAT_W-1:0]     status_reg, status_next;
    logic [DATA_W-1:0]     value_reg, value_next;
    logic [CNT_W-1:0]      length_reg, length_next;
    logic                  last_reg, last_next;

    // Decode signals
    logic                  accept;
    logic                  is_ins;
    logic                  is_del;
    logic                  full;
    logic                  empty;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      req_pos;
    logic                  ins_bad;
    logic                  del_bad;
    logic [CNT_W-1:0]      pos_c;
    logic                  go_shift;
    logic [IDX_W-1:0]      front_dec;
    logic [IDX_W-1:0]      front_inc;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Request decode and range checks
    always_comb
    begin
        is_ins  = (action == ACT_INS_FRONT) || (action == ACT_INS_BACK) ||
                  (action == ACT_INS_POS);
        is_del  = (action == ACT_DEL_FRONT) || (action == ACT_DEL_BACK) ||
                  (action == ACT_DEL_POS);
        full    = (count_reg == CNT_W'(LIST_DEPTH));
        empty   = (count_reg == '0);
        cnt_ext = CMP_W'(count_reg);
        case (action)
            ACT_INS_FRONT: req_pos = CMP_W'(1);
            ACT_INS_BACK:  req_pos = cnt_ext + CMP_W'(1);
            ACT_DEL_FRONT: req_pos = CMP_W'(1);
            ACT_DEL_BACK:  req_pos = cnt_ext;
            default:       req_pos = CMP_W'(position);
        endcase
        ins_bad  = (req_pos == '0) || (req_pos > cnt_ext + CMP_W'(1));
        del_bad  = (req_pos == '0) || (req_pos > cnt_ext);
        pos_c    = req_pos[CNT_W-1:0];
        // middle positions need entries moved
        go_shift = (is_ins && !full && !ins_bad && (req_pos != CMP_W'(1)) &&
                    (req_pos != cnt_ext + CMP_W'(1))) ||
                   (is_del && !empty && !del_bad && (req_pos != CMP_W'(1)) &&
                    (req_pos != cnt_ext));
        front_dec = (front_reg == '0) ? IDX_W'(LIST_DEPTH - 1) : front_reg - IDX_W'(1);
        front_inc = (front_reg == IDX_W'(LIST_DEPTH - 1)) ? '0 : front_reg + IDX_W'(1);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (go_shift)
                    begin
                        state_next = S_SHIFT;
                    end
                    else if ((action == ACT_DUMP) && !empty)
                    begin
                        state_next = S_DUMP;
                    end
                end
            end
            S_SHIFT:
            begin
                if (cur_reg == stop_reg)
                begin
                    state_next = S_SHIFT_DRAIN;
                end
            end
            S_SHIFT_DRAIN: state_next = S_FINISH;
            S_FINISH:      state_next = S_IDLE;
            S_DUMP:
            begin
                if (cur_reg == count_reg - CNT_W'(1))
                begin
                    state_next = S_DUMP_DRAIN;
                end
            end
            S_DUMP_DRAIN:  state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // Memory accesses, list state and results
    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        stop_next      = stop_reg;
        ins_next       = ins_reg;
        val_next       = val_reg;
        ins_slot_next  = ins_slot_reg;
        dst_next       = dst_reg;
        dump_last_next = dump_last_reg;
        rd_pend_next   = 1'b0;
        dump_pend_next = 1'b0;
        strobe_next    = 1'b0;
        status_next    = status_reg;
        value_next     = value_reg;
        length_next    = length_reg;
        last_next      = last_reg;
        ram_req        = '0;

        // write back an entry read in the previous cycle of a shift
        if (rd_pend_reg)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = dst_reg;
            ram_req.wdata = ram_rdata;
        end

        // dump entry read in the previous cycle goes out now
        if (dump_pend_reg)
        begin
            strobe_next = 1'b1;
            status_next = ST_OK;
            value_next  = ram_rdata;
            length_next = count_reg;
            last_next   = dump_last_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = item_value;
                    strobe_next = 1'b1;
                    status_next = ST_OK;
                    value_next  = '0;
                    length_next = count_reg;
                    last_next   = 1'b1;
                    if (action == ACT_DUMP)
                    begin
                        // empty list answers at once; otherwise walk from the front
                        strobe_next = empty;
                        cur_next    = '0;
                    end
                    else if (is_ins)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (ins_bad)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (go_shift)
                        begin
                            strobe_next   = 1'b0;
                            cur_next      = count_reg - CNT_W'(1);
                            stop_next     = pos_c - CNT_W'(1);
                            ins_next      = 1'b1;
                            ins_slot_next = slot_of(front_reg, pos_c - CNT_W'(1));
                        end
                        else
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.wdata = item_value;
                            if (pos_c == CNT_W'(1))
                            begin
                                front_next    = front_dec;
                                ram_req.waddr = front_dec;
                            end
                            else
                            begin
                                ram_req.waddr = slot_of(front_reg, count_reg);
                            end
                            count_next  = count_reg + CNT_W'(1);
                            length_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (is_del)
                    begin
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (del_bad)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (go_shift)
                        begin
                            strobe_next = 1'b0;
                            cur_next    = pos_c;
                            stop_next   = count_reg - CNT_W'(1);
                            ins_next    = 1'b0;
                        end
                        else
                        begin
                            if (count_reg == CNT_W'(1))
                            begin
                                front_next = '0;
                            end
                            else if (pos_c == CNT_W'(1))
                            begin
                                front_next = front_inc;
                            end
                            count_next  = count_reg - CNT_W'(1);
                            length_next = count_reg - CNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = ST_INVALID;
                    end
                end
            end
            S_SHIFT:
            begin
                // read one entry; it lands one place over in the next cycle
                ram_req.re    = 1'b1;
                ram_req.raddr = slot_of(front_reg, cur_reg);
                rd_pend_next  = 1'b1;
                dst_next      = slot_of(front_reg, ins_reg ? cur_reg + CNT_W'(1)
                                                           : cur_reg - CNT_W'(1));
                if (cur_reg != stop_reg)
                begin
                    cur_next = ins_reg ? cur_reg - CNT_W'(1) : cur_reg + CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                strobe_next = 1'b1;
                status_next = ST_OK;
                value_next  = '0;
                last_next   = 1'b1;
                if (ins_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = ins_slot_reg;
                    ram_req.wdata = val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    length_next   = count_reg + CNT_W'(1);
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    length_next = count_reg - CNT_W'(1);
                end
            end
            S_DUMP:
            begin
                ram_req.re     = 1'b1;
                ram_req.raddr  = slot_of(front_reg, cur_reg);
                dump_pend_next = 1'b1;
                dump_last_next = (cur_reg == count_reg - CNT_W'(1));
                cur_next       = cur_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            dump_pend_reg <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            dump_pend_reg <= dump_pend_next;
            strobe_reg    <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        stop_reg      <= stop_next;
        ins_reg       <= ins_next;
        val_reg       <= val_next;
        ins_slot_reg  <= ins_slot_next;
        dst_reg       <= dst_next;
        dump_last_reg <= dump_last_next;
        status_reg    <= status_next;
        value_reg     <= value_next;
        length_reg    <= length_next;
        last_reg      <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign status        = status_reg;
    assign entry_value   = value_reg;
    assign list_length   = length_reg;
    assign last_result   = last_reg;

    // Checks
    `PDL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(LIST_DEPTH), "count over depth")
    `PDL_ASSERT_NOW(a_empty_front, clk, rst_n, count_reg == '0, front_reg == '0, "empty list with front off zero")
    `PDL_ASSERT_NOW(a_ram_collide, clk, rst_n, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "read and write hit one slot")
    `PDL_ASSERT_NOW(a_empty_len, clk, rst_n, strobe_reg && status_reg == ST_EMPTY, length_reg == '0, "empty status with entries")
    `PDL_ASSERT_NEXT(a_dump_run, clk, rst_n, strobe_reg && !last_reg, strobe_reg, "gap inside a dump")

endmodule

[design/positional_deque_list_top.sv]
// Front/back insert or delete, errors and empty dump: result registered in the cycle after start.
// Positional insert/delete in the middle: entries move in S_SHIFT, then S_SHIFT_DRAIN and S_FINISH, one entry
//   moved per cycle through the entry RAM (moves = entries behind the position); result registered from S_FINISH.
// Dump: entries are read in S_DUMP and output from the registered RAM data, then one per cycle; busy to S_DUMP_DRAIN.
// Throughput: one transaction per cycle for front/back actions; middle moves and dumps hold busy until done.
// Reset: list empty, front cleared; RAM contents undefined, no clearing pass.
module positional_deque_list_top
    import pdl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACT_W-1:0]         action,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [POS_W-1:0]         position,
    output logic                     result_strobe,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] entry_value,
    output logic [CNT_W-1:0]         list_length,
    output logic                     last_result
);

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    // List controller
    pdl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .action        (action),
        .item_value    (item_value),
        .position      (position),
        .busy          (busy),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .result_strobe (result_strobe),
        .status        (status),
        .entry_value   (entry_value),
        .list_length   (list_length),
        .last_result   (last_result)
    );

    // Entry storage
    pdl_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import pdl_pkg::*;

    // Action code 7 has no package name; the block must answer it as invalid
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_OPS   = 420;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } list_op_t;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         length;
        logic                     last;
    } list_result_t;

    // Clock, reset and block inputs, all known from time zero
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [ACT_W-1:0]         action = '0;
    logic signed [DATA_W-1:0] item_value = '0;
    logic [POS_W-1:0]         position = '0;

    logic                     busy;
    logic                     result_strobe;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] entry_value;
    logic [CNT_W-1:0]         list_length;
    logic                     last_result;

    // Pending operations, list shadow and expected results
    list_op_t                 pending_ops[$];
    logic signed [DATA_W-1:0] list_shadow[$];
    list_result_t             expected_results[$];

    int plan_len;
    int ops_planned;
    int ops_sent;
    int ops_accepted;
    int results_checked;
    int error_count;
    int idle_cycles;
    int max_length;
    int status_seen[4];

    positional_deque_list_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .item_value    (item_value),
        .position      (position),
        .result_strobe (result_strobe),
        .status        (status),
        .entry_value   (entry_value),
        .list_length   (list_length),
        .last_result   (last_result)
    );

    always #5 clk = ~clk;

    // Apply one accepted transaction to the shadow list and queue its results
    task automatic predict_list_op(input logic [ACT_W-1:0] act,
                                   input logic signed [DATA_W-1:0] val,
                                   input logic [POS_W-1:0] pos);
        int n;
        int where;
        logic [STAT_W-1:0] st;
        n = list_shadow.size();
        st = ST_OK;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS:
            begin
                where = (act == ACT_INS_FRONT) ? 1 : (act == ACT_INS_BACK) ? n + 1 : int'(pos);
                // full is checked before the position
                if (n >= LIST_DEPTH)
                    st = ST_FULL;
                else if (where < 1 || where > n + 1)
                    st = ST_INVALID;
                else if (where == n + 1)
                    list_shadow.push_back(val);
                else
                    list_shadow.insert(where - 1, val);
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS:
            begin
                where = (act == ACT_DEL_FRONT) ? 1 : (act == ACT_DEL_BACK) ? n : int'(pos);
                // empty is checked before the position
                if (n == 0)
                    st = ST_EMPTY;
                else if (where < 1 || where > n)
                    st = ST_INVALID;
                else
                    list_shadow.delete(where - 1);
            end
            ACT_DUMP:
            begin
                if (n == 0)
                    expected_results.push_back('{ST_OK, '0, '0, 1'b1});
                for (int i = 0; i < n; i++)
                    expected_results.push_back('{ST_OK, list_shadow[i], CNT_W'(n),
                                                 (i == n - 1)});
            end
            default:
                st = ST_INVALID;
        endcase
        if (act != ACT_DUMP)
            expected_results.push_back('{st, '0, CNT_W'(list_shadow.size()), 1'b1});
        if (list_shadow.size() > max_length)
            max_length = list_shadow.size();
    endtask

    // Queue an operation and track the list length it leaves behind
    task automatic queue_op(input logic [ACT_W-1:0] act,
                            input logic signed [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos);
        int where;
        pending_ops.push_back('{act, val, pos});
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS:
            begin
                where = (act == ACT_INS_POS) ? int'(pos) : 1;
                if (plan_len < LIST_DEPTH && where >= 1 && where <= plan_len + 1)
                    plan_len++;
            end
            ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_POS:
            begin
                where = (act == ACT_DEL_POS) ? int'(pos) : 1;
                if (plan_len > 0 && where >= 1 && where <= plan_len)
                    plan_len--;
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $urandom_range(0, 15);
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    // One insert of random kind at a legal position (or beyond it on a full list)
    task automatic queue_insert();
        logic [ACT_W-1:0] act;
        case ($urandom_range(0, 2))
            0: act = ACT_INS_FRONT;
            1: act = ACT_INS_BACK;
            default: act = ACT_INS_POS;
        endcase
        queue_op(act, pick_value(), POS_W'($urandom_range(1, plan_len + 1)));
    endtask

    task automatic queue_delete();
        logic [ACT_W-1:0] act;
        case ($urandom_range(0, 2))
            0: act = ACT_DEL_FRONT;
            1: act = ACT_DEL_BACK;
            default: act = ACT_DEL_POS;
        endcase
        queue_op(act, pick_value(), POS_W'((plan_len == 0) ? $urandom_range(0, 3)
                                                           : $urandom_range(1, plan_len)));
    endtask

    task automatic fill_list();
        while (plan_len < LIST_DEPTH)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_op(ACT_DUMP, pick_value(), POS_W'($urandom));
            queue_insert();
        end
        // inserts against a full list, some with bad positions as well
        repeat ($urandom_range(1, 3))
            queue_op(ACT_W'($urandom_range(0, 2)), pick_value(),
                     POS_W'($urandom_range(0, 255)));
        queue_op(ACT_DUMP, pick_value(), POS_W'($urandom));
    endtask

    task automatic drain_list();
        while (plan_len > 0)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_op(ACT_DUMP, pick_value(), POS_W'($urandom));
            queue_delete();
        end
        repeat ($urandom_range(1, 2))
            queue_delete();
    endtask

    // Stimulus: directed corner cases, then bursts of well-formed and noisy traffic
    initial
    begin
        plan_len = 0;
        queue_op(ACT_DUMP,      '0, '0);
        queue_op(ACT_DEL_FRONT, '0, '0);
        queue_op(ACT_DEL_BACK,  '0, '0);
        queue_op(ACT_DEL_POS,   '0, 8'd1);
        queue_op(ACT_INS_POS,   32'sd5, 8'd0);
        queue_op(ACT_INS_POS,   32'sd6, 8'd2);
        queue_op(ACT_INS_FRONT, 32'sh7FFF_FFFF, 8'd0);
        queue_op(ACT_INS_BACK,  32'sh8000_0000, 8'hFF);
        queue_op(ACT_INS_POS,   -32'sd1, 8'd3);
        queue_op(ACT_INS_POS,   32'sd1, 8'd1);
        queue_op(ACT_INS_POS,   32'sh1234_5678, 8'd3);
        queue_op(ACT_INS_POS,   32'sh0BAD_F00D, 8'd255);
        queue_op(ACT_DUMP,      '0, '0);
        queue_op(ACT_UNUSED,    -32'sd1, 8'hFF);
        queue_op(ACT_DEL_POS,   '0, 8'd0);
        queue_op(ACT_DEL_POS,   '0, 8'd6);
        queue_op(ACT_DEL_POS,   '0, 8'd3);
        queue_op(ACT_DEL_POS,   '0, 8'd4);
        queue_op(ACT_DEL_FRONT, '0, '0);
        queue_op(ACT_DEL_BACK,  '0, '0);
        queue_op(ACT_DUMP,      '0, '0);
        queue_op(ACT_DEL_POS,   '0, 8'd1);
        queue_op(ACT_DUMP,      '0, '0);

        fill_list();
        drain_list();
        while (pending_ops.size() < RANDOM_OPS)
        begin
            case ($urandom_range(0, 5))
                0: fill_list();
                1: drain_list();
                2:
                begin
                    // pure noise: any code, any position
                    repeat (6)
                        queue_op(ACT_W'($urandom_range(0, 7)), $urandom,
                                 POS_W'($urandom_range(0, 255)));
                end
                default:
                begin
                    // mixed traffic at legal and edge positions
                    repeat (12)
                    begin
                        case ($urandom_range(0, 7))
                            0, 1, 2: queue_insert();
                            3, 4, 5: queue_delete();
                            6: queue_op(ACT_DUMP, pick_value(), POS_W'($urandom));
                            default:
                                queue_op($urandom_range(0, 1) ? ACT_INS_POS : ACT_DEL_POS,
                                         pick_value(),
                                         POS_W'(plan_len + $urandom_range(0, 2)));
                        endcase
                    end
                end
            endcase
        end
        ops_planned = pending_ops.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_accepted != ops_planned || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end

        $display("Run covered %0d list transactions, %0d results checked, longest list %0d.",
                 ops_accepted, results_checked, max_length);
        $display("Statuses seen: ok %0d, invalid %0d, full %0d, empty %0d; %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], error_count);
        if (error_count == 0)
            $display("** positional_deque_list_top: PASSED **");
        else
            $display("** positional_deque_list_top: FAILED **");
        $finish;
    end

    // Driver: hold a transaction until taken, then issue the next or idle
    always @(posedge clk)
    begin
        list_op_t next_op;
        int       idle_pct;
        if (rst_n && !(start && busy))
        begin
            if (start)
            begin
                predict_list_op(action, item_value, position);
                ops_accepted++;
            end
            // sender idle rate by phase: 38%, then 57%, then none
            idle_pct = (ops_sent < 150) ? 38 : (ops_sent < 300) ? 57 : 0;
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                next_op = pending_ops.pop_front();
                start      <= 1'b1;
                action     <= next_op.action;
                item_value <= next_op.value;
                position   <= next_op.position;
                ops_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result against the oldest expectation
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && result_strobe)
        begin
            results_checked++;
            status_seen[status]++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d, entry_value %0d, list_length %0d",
                       status, entry_value, list_length);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (entry_value !== want.value)
                begin
                    $error("entry_value mismatch: expected %0d, got %0d",
                           want.value, entry_value);
                    error_count++;
                end
                if (list_length !== want.length)
                begin
                    $error("list_length mismatch: expected %0d, got %0d",
                           want.length, list_length);
                    error_count++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result mismatch: expected %0d, got %0d",
                           want.last, last_result);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any accepted transaction or result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_strobe)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("** positional_deque_list_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
